@@ rtl/core/hpz_pkg.sv @@
// ----------------------------------------------------------------------------
// hpz_pkg
// Shared constants, types and the CORDIC angle table for helix_point_at_z.
// ----------------------------------------------------------------------------
package hpz_pkg;

    localparam int CORDIC_STAGES = 24;
    localparam int DIV_STEPS     = 63;
    localparam int NUM_BITS      = 31;
    localparam int GUARD_BITS    = 6;
    localparam int XW            = 44;
    localparam int ZW            = 33;
    localparam int MW            = XW + 24;

    localparam logic [30:0] TWO_PI_Q28   = 31'd1686629713;
    localparam logic signed [23:0] INV_GAIN_Q23 = 24'sd5094007;

    typedef enum logic [2:0] {
        REG_CENTER_X = 3'd0,
        REG_CENTER_Y = 3'd1,
        REG_ORIGIN_X = 3'd2,
        REG_ORIGIN_Y = 3'd3,
        REG_ORIGIN_Z = 3'd4,
        REG_PITCH    = 3'd5
    } t_reg_idx;

    function automatic logic [31:0] atan_turn(input int idx);
        logic [31:0] v;
        case (idx)
            0:  v = 32'h20000000;  1:  v = 32'h12E4051E;
            2:  v = 32'h09FB385B;  3:  v = 32'h051111D4;
            4:  v = 32'h028B0D43;  5:  v = 32'h0145D7E1;
            6:  v = 32'h00A2F61E;  7:  v = 32'h00517C55;
            8:  v = 32'h0028BE53;  9:  v = 32'h00145F2F;
            10: v = 32'h000A2F98;  11: v = 32'h000517CC;
            12: v = 32'h00028BE6;  13: v = 32'h000145F3;
            14: v = 32'h0000A2FA;  15: v = 32'h0000517D;
            16: v = 32'h000028BE;  17: v = 32'h0000145F;
            18: v = 32'h00000A30;  19: v = 32'h00000518;
            20: v = 32'h0000028C;  21: v = 32'h00000146;
            22: v = 32'h000000A3;  23: v = 32'h00000051;
            24: v = 32'h00000029;  25: v = 32'h00000014;
            26: v = 32'h0000000A;  27: v = 32'h00000005;
            28: v = 32'h00000003;  29: v = 32'h00000001;
            30: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/core/helix_point_at_z.sv @@
// ----------------------------------------------------------------------------
// helix_point_at_z
// Point on a helix at a requested z: angle by pipelined division, CORDIC turn.
// ----------------------------------------------------------------------------
// channel  | dir | transaction
// s_*      | in  | z_query
// m_*      | out | point_x, point_y, point_z; tuser pitch_error
// apb      | in  | register writes and reads
//
// One query per cycle while the output is not stalled; stages: 4 setup, 63 restoring
// division steps, 2 angle stages, 24 CORDIC stages, multiply, output.
// Synchronous reset clears all valid bits and sets pitch to 1.0.
// A stalled output freezes the whole pipeline; nothing is dropped.
// ----------------------------------------------------------------------------
module helix_point_at_z (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [31:0]  s_tdata,   // z_query
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [95:0]  m_tdata,   // point_x, point_y, point_z
    output logic         m_tuser,   // pitch_error
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import hpz_pkg::*;

    logic [31:0] r_cx, r_cy, r_ox, r_oy, r_oz, r_pitch;
    logic [2:0]  w_idx;
    logic        en;

    assign pready = 1'b1;
    assign w_idx  = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx <= '0; r_cy <= '0; r_ox <= '0; r_oy <= '0; r_oz <= '0;
            r_pitch <= 32'd65536;
        end else if (psel && penable && pwrite) begin
            case (w_idx)
                REG_CENTER_X: r_cx    <= pwdata;
                REG_CENTER_Y: r_cy    <= pwdata;
                REG_ORIGIN_X: r_ox    <= pwdata;
                REG_ORIGIN_Y: r_oy    <= pwdata;
                REG_ORIGIN_Z: r_oz    <= pwdata;
                REG_PITCH:    r_pitch <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_CENTER_X: prdata = r_cx;
            REG_CENTER_Y: prdata = r_cy;
            REG_ORIGIN_X: prdata = r_ox;
            REG_ORIGIN_Y: prdata = r_oy;
            REG_ORIGIN_Z: prdata = r_oz;
            REG_PITCH:    prdata = r_pitch;
            default:      prdata = '0;
        endcase
    end

    logic r_ov;
    assign en       = !r_ov || m_tready;
    assign s_tready = en;

    // setup stages
    logic               r_a_v, r_b_v, r_c_v;
    logic [31:0]        r_a_zq, r_b_zq, r_c_zq;
    logic signed [32:0] r_a_dz;
    logic [31:0]        r_a_p;
    logic [32:0]        r_b_absdz, r_c_absdz;
    logic [31:0]        r_b_absp, r_c_absp;
    logic               r_b_neg, r_b_err, r_c_neg, r_c_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0; r_b_v <= 1'b0; r_c_v <= 1'b0;
        end else if (en) begin
            r_a_v <= s_tvalid; r_b_v <= r_a_v; r_c_v <= r_b_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_zq    <= s_tdata;
            r_a_dz    <= $signed({s_tdata[31], s_tdata}) - $signed({r_oz[31], r_oz});
            r_a_p     <= r_pitch;
            r_b_zq    <= r_a_zq;
            r_b_absdz <= r_a_dz[32] ? 33'(-r_a_dz) : r_a_dz[32:0];
            r_b_absp  <= r_a_p[31] ? 32'(-r_a_p) : r_a_p;
            r_b_neg   <= r_a_dz[32] ^ r_a_p[31];
            r_b_err   <= (r_a_p == '0);
            r_c_zq    <= r_b_zq;
            r_c_absdz <= r_b_absdz;
            r_c_absp  <= r_b_absp;
            r_c_neg   <= r_b_neg;
            r_c_err   <= r_b_err;
        end
    end

    // division pipeline
    logic        r_dv   [DIV_STEPS+1];
    logic [63:0] r_rem  [DIV_STEPS+1];
    logic [62:0] r_big  [DIV_STEPS+1];
    logic [2:0]  r_num  [DIV_STEPS+1];
    logic [31:0] r_t    [DIV_STEPS+1];
    logic        r_neg  [DIV_STEPS+1];
    logic        r_derr [DIV_STEPS+1];
    logic [31:0] r_dzq  [DIV_STEPS+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_dv[0] <= 1'b0;
        else if (en)  r_dv[0] <= r_c_v;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_big[0]  <= 63'(r_c_absp * TWO_PI_Q28);
            r_rem[0]  <= 64'(r_c_absdz[32:3]);
            r_num[0]  <= r_c_absdz[2:0];
            r_t[0]    <= '0;
            r_neg[0]  <= r_c_neg;
            r_derr[0] <= r_c_err;
            r_dzq[0]  <= r_c_zq;
        end
    end

    for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
        localparam int NB = NUM_BITS - 1 - j;
        logic        w_bit, w_ge;
        logic [63:0] w_sh;

        if (NB >= 28) begin : g_nb
            assign w_bit = r_num[j][NB-28];
        end else begin : g_zb
            assign w_bit = 1'b0;
        end
        assign w_sh = {r_rem[j][62:0], w_bit};
        assign w_ge = (w_sh >= {1'b0, r_big[j]});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_dv[j+1] <= 1'b0;
            else if (en)  r_dv[j+1] <= r_dv[j];
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_rem[j+1]  <= w_ge ? w_sh - {1'b0, r_big[j]} : w_sh;
                r_big[j+1]  <= r_big[j];
                r_num[j+1]  <= r_num[j];
                r_t[j+1]    <= {r_t[j][30:0], w_ge};
                r_neg[j+1]  <= r_neg[j];
                r_derr[j+1] <= r_derr[j];
                r_dzq[j+1]  <= r_dzq[j];
            end
        end
    end

    // angle sign and quarter turn
    logic               r_d_v, r_e_v, r_d_err, r_e_err;
    logic [31:0]        r_d_t, r_d_zq, r_e_zq;
    logic signed [33:0] r_d_vx, r_d_vy;
    logic signed [33:0] w_qx, w_qy;

    always_comb begin
        case (r_d_t[31:30])
            2'd0:    begin w_qx = r_d_vx;  w_qy = r_d_vy;  end
            2'd1:    begin w_qx = -r_d_vy; w_qy = r_d_vx;  end
            2'd2:    begin w_qx = -r_d_vx; w_qy = -r_d_vy; end
            default: begin w_qx = r_d_vy;  w_qy = -r_d_vx; end
        endcase
    end

    logic               r_cv  [CORDIC_STAGES+1];
    logic signed [XW-1:0] r_x [CORDIC_STAGES+1];
    logic signed [XW-1:0] r_y [CORDIC_STAGES+1];
    logic signed [ZW-1:0] r_z [CORDIC_STAGES+1];
    logic               r_cerr [CORDIC_STAGES+1];
    logic [31:0]        r_czq  [CORDIC_STAGES+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_v <= 1'b0; r_cv[0] <= 1'b0;
        end else if (en) begin
            r_d_v <= r_dv[DIV_STEPS]; r_cv[0] <= r_d_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d_t     <= r_neg[DIV_STEPS] ? 32'(-r_t[DIV_STEPS]) : r_t[DIV_STEPS];
            r_d_err   <= r_derr[DIV_STEPS];
            r_d_zq    <= r_dzq[DIV_STEPS];
            r_d_vx    <= 34'($signed({r_ox[31], r_ox}) - $signed({r_cx[31], r_cx}));
            r_d_vy    <= 34'($signed({r_oy[31], r_oy}) - $signed({r_cy[31], r_cy}));
            r_x[0]    <= XW'(w_qx) <<< GUARD_BITS;
            r_y[0]    <= XW'(w_qy) <<< GUARD_BITS;
            r_z[0]    <= $signed({3'b000, r_d_t[29:0]});
            r_cerr[0] <= r_d_err;
            r_czq[0]  <= r_d_zq;
        end
    end

    for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
        localparam logic [ZW-1:0] ANG = ZW'(atan_turn(k));
        logic signed [XW-1:0] w_dx, w_dy;
        assign w_dx = r_y[k] >>> k;
        assign w_dy = r_x[k] >>> k;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_cv[k+1] <= 1'b0;
            else if (en)  r_cv[k+1] <= r_cv[k];
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                if (!r_z[k][ZW-1]) begin
                    r_x[k+1] <= r_x[k] - w_dx;
                    r_y[k+1] <= r_y[k] + w_dy;
                    r_z[k+1] <= r_z[k] - $signed(ANG);
                end else begin
                    r_x[k+1] <= r_x[k] + w_dx;
                    r_y[k+1] <= r_y[k] - w_dy;
                    r_z[k+1] <= r_z[k] + $signed(ANG);
                end
                r_cerr[k+1] <= r_cerr[k];
                r_czq[k+1]  <= r_czq[k];
            end
        end
    end

    // gain correction, centre add, saturation
    logic                 r_e_v2;
    logic signed [MW-1:0] r_px, r_py;
    logic signed [MW-1:0] w_rx, w_ry;
    logic signed [39:0]   w_sx, w_sy;
    logic [31:0]          w_ox, w_oy;
    logic [31:0]          r_oxo, r_oyo, r_ozo;
    logic                 r_oerr;

    assign r_e_v2 = r_e_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_v <= 1'b0; r_ov <= 1'b0;
        end else if (en) begin
            r_e_v <= r_cv[CORDIC_STAGES]; r_ov <= r_e_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_px    <= MW'(r_x[CORDIC_STAGES]) * MW'(INV_GAIN_Q23);
            r_py    <= MW'(r_y[CORDIC_STAGES]) * MW'(INV_GAIN_Q23);
            r_e_err <= r_cerr[CORDIC_STAGES];
            r_e_zq  <= r_czq[CORDIC_STAGES];
        end
    end

    assign w_rx = (r_px + (MW'(1) <<< 28)) >>> 29;
    assign w_ry = (r_py + (MW'(1) <<< 28)) >>> 29;
    assign w_sx = 40'($signed(r_cx)) + 40'(w_rx);
    assign w_sy = 40'($signed(r_cy)) + 40'(w_ry);

    always_comb begin
        if (w_sx > 40'sd2147483647)       w_ox = 32'h7FFFFFFF;
        else if (w_sx < -40'sd2147483648) w_ox = 32'h80000000;
        else                              w_ox = w_sx[31:0];
        if (w_sy > 40'sd2147483647)       w_oy = 32'h7FFFFFFF;
        else if (w_sy < -40'sd2147483648) w_oy = 32'h80000000;
        else                              w_oy = w_sy[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_oxo  <= r_e_err ? '0 : w_ox;
            r_oyo  <= r_e_err ? '0 : w_oy;
            r_ozo  <= r_e_zq;
            r_oerr <= r_e_err;
        end
    end

    assign m_tvalid = r_ov;
    assign m_tdata  = {r_ozo, r_oyo, r_oxo};
    assign m_tuser  = r_oerr;

endmodule
